@@ hdl/grs_pkg.sv @@
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types and constants for the graph reachability search block.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int NODE_W = 4;
    localparam int EDGE_W = 16;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Write request into the adjacency memory, carried as the raw request fields.
    typedef struct packed
    {
        logic              en;
        logic [NODE_W-1:0] node;
        logic [EDGE_W-1:0] edges;
    } adj_wr_t;

endpackage

@@ hdl/grs_adj_mem.sv @@
// ----------------------------------------------------------------------------
// grs_adj_mem
// Adjacency row memory with one synchronous read port and per-row valid bits.
// ----------------------------------------------------------------------------
module grs_adj_mem
    import grs_pkg::*;
#(
    parameter int NODES = 16,
    localparam int AW = $clog2(NODES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  adj_wr_t          wr,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [NODES-1:0] rd_row
);

    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] row_valid_reg;
    logic [NODES-1:0] rd_data_reg;
    logic             rd_valid_reg;

    logic [31:0]      wr_idx;
    logic             wr_hit;
    logic [AW-1:0]    wr_addr;
    logic [NODES-1:0] wr_row;

    // Rows beyond the graph are ignored; edge bits beyond the graph are dropped.
    assign wr_idx  = 32'(wr.node);
    assign wr_hit  = wr.en && (wr_idx < NODES);
    assign wr_addr = wr_idx[AW-1:0];
    assign wr_row  = NODES'({{NODES{1'b0}}, wr.edges});

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // A row never loaded since reset has no edges.
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ hdl/graph_reachability_search_top.sv @@
// ----------------------------------------------------------------------------
// graph_reachability_search_top
// Directed graph reachability over a loadable adjacency matrix.
// ----------------------------------------------------------------------------
// A load request (op = 0) writes one adjacency row and returns nothing. A
// query request (op = 1) returns one response: 1 when target_node is
// reachable from source_node, and 1 at once when the two are equal. A query
// naming a node outside the graph, or equal source and target, goes straight
// to the finish state. Otherwise the search is a depth-first walk on a stack
// memory: every node taken off the stack passes a stack read, an adjacency
// row read and an edge check, and every new neighbor is then pushed. Each
// memory returns its data in the cycle after the read, the row read needs the
// stack data, and the stack takes one push per cycle.
// The search stops as soon as the target shows up among the new neighbors.
// One query is in work at a time; a finished response waits in an output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module graph_reachability_search_top
    import grs_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              req_valid,
    output logic              req_stall,
    input  logic              op,
    input  logic [NODE_W-1:0] row_node,
    input  logic [EDGE_W-1:0] row_edges,
    input  logic [NODE_W-1:0] source_node,
    input  logic [NODE_W-1:0] target_node,

    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              reachable
);

    localparam int AW = $clog2(NODES);
    localparam int DW = $clog2(NODES + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_POP,
        ST_FETCH,
        ST_ROW,
        ST_PUSH,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [NODES-1:0] pending_reg, pending_next;
    logic [AW-1:0]    target_reg, target_next;
    logic             result_reg, result_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             reachable_reg, reachable_next;

    // Stack memory.
    logic [AW-1:0]    stk [NODES];
    logic [AW-1:0]    stk_rdata_reg;
    logic             stk_we;
    logic [AW-1:0]    stk_waddr;
    logic [AW-1:0]    stk_wdata;
    logic             stk_re;
    logic [AW-1:0]    stk_raddr;

    adj_wr_t          adj_wr;
    logic             adj_rd_en;
    logic [NODES-1:0] adj_row;

    logic             req_fire;
    logic [31:0]      src32;
    logic [31:0]      tgt32;
    logic [AW-1:0]    src_idx;
    logic [AW-1:0]    tgt_idx;
    logic             nodes_ok;
    logic [NODES-1:0] fresh;
    logic [NODES-1:0] pending_low;
    logic [NODES-1:0] pending_rest;
    logic [AW-1:0]    pick_idx;
    logic [DW-1:0]    depth_dec;

    grs_adj_mem #(
        .NODES (NODES)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (adj_wr),
        .rd_en   (adj_rd_en),
        .rd_addr (stk_rdata_reg),
        .rd_row  (adj_row)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign reachable = reachable_reg;

    assign adj_wr.en    = req_fire && (op == OP_LOAD);
    assign adj_wr.node  = row_node;
    assign adj_wr.edges = row_edges;

    assign src32    = 32'(source_node);
    assign tgt32    = 32'(target_node);
    assign src_idx  = src32[AW-1:0];
    assign tgt_idx  = tgt32[AW-1:0];
    assign nodes_ok = (src32 < NODES) && (tgt32 < NODES);

    assign fresh        = adj_row & ~visited_reg;
    assign pending_low  = pending_reg & (~pending_reg + NODES'(1));
    assign pending_rest = pending_reg & ~pending_low;
    assign depth_dec    = depth_reg - DW'(1);

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (pending_low[i])
            begin
                pick_idx = pick_idx | AW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk[stk_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        visited_next   = visited_reg;
        pending_next   = pending_reg;
        target_next    = target_reg;
        result_next    = result_reg;
        rsp_valid_next = rsp_valid_reg;
        reachable_next = reachable_reg;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = src_idx;
        stk_re         = 1'b0;
        stk_raddr      = depth_dec[AW-1:0];
        adj_rd_en      = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (op == OP_QUERY))
                begin
                    if (source_node == target_node)
                    begin
                        result_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else if (!nodes_ok)
                    begin
                        result_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        // The source itself is not marked visited.
                        visited_next = '0;
                        stk_we       = 1'b1;
                        stk_waddr    = '0;
                        stk_wdata    = src_idx;
                        depth_next   = DW'(1);
                        target_next  = tgt_idx;
                        state_next   = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    result_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_dec;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                adj_rd_en  = 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                // Once the target is among the new neighbors it is reachable.
                if (fresh[target_reg])
                begin
                    result_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    visited_next = visited_reg | fresh;
                    pending_next = fresh;
                    state_next   = (fresh == '0) ? ST_POP : ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (32'(depth_reg) < NODES)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_reg[AW-1:0];
                    stk_wdata  = pick_idx;
                    depth_next = depth_reg + DW'(1);
                end
                pending_next = pending_rest;
                if (pending_rest == '0)
                begin
                    state_next = ST_POP;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    reachable_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            visited_reg   <= '0;
            pending_reg   <= '0;
            target_reg    <= '0;
            result_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            reachable_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            pending_reg   <= pending_next;
            target_reg    <= target_next;
            result_reg    <= result_next;
            rsp_valid_reg <= rsp_valid_next;
            reachable_reg <= reachable_next;
        end
    end

endmodule

@@ tb/sv/tb_graph_reachability_search_top.sv @@
// ----------------------------------------------------------------------------
// tb_graph_reachability_search_top
// Self-checking testbench for the graph reachability search block.
// ----------------------------------------------------------------------------
// Adjacency rows are loaded and reachability queries are sent through the
// request channel. A local copy of the adjacency matrix predicts every query
// answer as a transitive closure. Each response is checked against the oldest
// outstanding answer. Directed cases come first: empty graph, self loops,
// full and empty rows, cycles. Then random graphs of varying edge density are
// loaded and queried, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_graph_reachability_search_top;

    timeunit 1ns;
    timeprecision 1ps;

    import grs_pkg::*;

    localparam int NODES         = 16;
    localparam int SETTLE_CYCLES = 4 * NODES + 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 6;

    typedef struct
    {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic              answer;
    } reach_query_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              op;
    logic [NODE_W-1:0] row_node;
    logic [EDGE_W-1:0] row_edges;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic              reachable;

    logic [NODES-1:0]  graph_rows [NODES];
    reach_query_t      pending_answers [$];
    int                error_count = 0;
    int                cycle_count = 0;
    bit                no_idle = 1'b0;

    graph_reachability_search_top #(.NODES(NODES)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .op          (op),
        .row_node    (row_node),
        .row_edges   (row_edges),
        .source_node (source_node),
        .target_node (target_node),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .reachable   (reachable)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("graph_reachability_search_top verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Closure of the successors of src; the source itself only counts when
    // it lies on a cycle, except for the trivial src == dst case.
    function automatic logic path_exists(input logic [NODE_W-1:0] src,
                                         input logic [NODE_W-1:0] dst);
        logic [NODES-1:0] seen;
        if (src == dst)
            return 1'b1;
        if (src >= NODES || dst >= NODES)
            return 1'b0;
        seen = graph_rows[src];
        for (int pass = 0; pass < NODES; pass++)
            for (int i = 0; i < NODES; i++)
                if (seen[i])
                    seen |= graph_rows[i];
        return seen[dst];
    endfunction

    function automatic logic [EDGE_W-1:0] random_row(input int pct);
        logic [EDGE_W-1:0] edges;
        for (int i = 0; i < EDGE_W; i++)
            edges[i] = ($urandom_range(99) < pct);
        return edges;
    endfunction

    task automatic send_request(input op_t             kind,
                                input logic [NODE_W-1:0] node,
                                input logic [EDGE_W-1:0] edges,
                                input logic [NODE_W-1:0] src,
                                input logic [NODE_W-1:0] dst);
        reach_query_t q;
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid   = 1'b1;
        op          = kind;
        row_node    = node;
        row_edges   = edges;
        source_node = src;
        target_node = dst;
        do
            @(posedge clk);
        while (req_stall);
        if (kind == OP_LOAD)
        begin
            if (node < NODES)
                graph_rows[node] = edges[NODES-1:0];
        end
        else
        begin
            q.src    = src;
            q.dst    = dst;
            q.answer = path_exists(src, dst);
            pending_answers.push_back(q);
        end
    endtask

    task automatic load_row(input int node, input logic [EDGE_W-1:0] edges);
        send_request(OP_LOAD, NODE_W'(node), edges,
                     NODE_W'($urandom_range(15)), NODE_W'($urandom_range(15)));
    endtask

    task automatic query(input int src, input int dst);
        send_request(OP_QUERY, NODE_W'($urandom_range(15)), EDGE_W'($urandom),
                     NODE_W'(src), NODE_W'(dst));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_empty_graph();
        query(0, 0);
        query(15, 15);
        query(0, 15);
        query(15, 0);
    endtask

    task automatic test_directed_paths();
        // A self loop must not reach anything else.
        load_row(0, 16'h0001);
        query(0, 1);
        load_row(0, 16'h8000);
        load_row(15, 16'hFFFF);
        query(0, 7);
        query(7, 0);
        load_row(7, 16'h0000);
        query(0, 1);
        load_row(15, 16'h0000);
        query(0, 1);
        query(0, 15);
        // Cycle 1 -> 2 -> 3 -> 1.
        load_row(1, 16'h0004);
        load_row(2, 16'h0008);
        load_row(3, 16'h0002);
        query(1, 3);
        query(3, 1);
        query(2, 0);
        query(2, 2);
    endtask

    // Each round loads a whole random graph and then queries it; a few row
    // reloads land between the queries.
    task automatic test_random_graphs(input int rounds, input int first_round);
        int density_pct [7] = '{0, 3, 6, 10, 20, 50, 100};
        int pct;
        int start;
        for (int r = first_round; r < first_round + rounds; r++)
        begin
            pct   = density_pct[r % 7];
            start = $urandom_range(15);
            for (int k = 0; k < NODES; k++)
                load_row((start + k) % NODES, random_row(pct));
            for (int k = 0; k < 30; k++)
            begin
                if ($urandom_range(99) < 10)
                    load_row($urandom_range(15), $urandom_range(99) < 50 ?
                             random_row(pct) : 16'($urandom));
                query($urandom_range(15), $urandom_range(15));
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_graphs(2, 2);
        no_idle = 1'b0;
    endtask

    task automatic test_query_after_drain();
        test_random_graphs(1, 4);
        wait_drained();
        test_random_graphs(1, 5);
    endtask

    always @(negedge clk)
        rsp_stall = (!no_idle && $urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin : check_responses
        reach_query_t q;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("response with no query outstanding");
            else
            begin
                q = pending_answers.pop_front();
                if (reachable !== q.answer)
                    report_mismatch($sformatf("query %0d -> %0d: reachable %b, expected %b",
                                              q.src, q.dst, reachable, q.answer));
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        op          = OP_LOAD;
        row_node    = '0;
        row_edges   = '0;
        source_node = '0;
        target_node = '0;
        for (int i = 0; i < NODES; i++)
            graph_rows[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_graph();
        test_directed_paths();
        test_random_graphs(6, 0);
        test_back_to_back();
        test_query_after_drain();
        test_random_graphs(3, 6);

        wait_drained();
        if (error_count == 0)
            $display("graph_reachability_search_top verification clean");
        else
            $display("graph_reachability_search_top verification failed");
        $finish;
    end

endmodule
